// File: hw/rtl/pts_pkg.sv
package pts_pkg;

  localparam int POSITION_BITS = 24;
  localparam int LENGTH_LIMIT  = 255;
  localparam int LEN_BITS      = 8;
  localparam int KIND_BITS     = 7;
  localparam int KW_COUNT      = 54;
  localparam int KW_MAX_LEN    = 14;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

  localparam logic [KIND_BITS-1:0] KIND_INTEGER  = 7'd54;
  localparam logic [KIND_BITS-1:0] KIND_REAL     = 7'd55;
  localparam logic [KIND_BITS-1:0] KIND_IDENT    = 7'd56;
  localparam logic [KIND_BITS-1:0] KIND_PLUS     = 7'd57;
  localparam logic [KIND_BITS-1:0] KIND_MINUS    = 7'd58;
  localparam logic [KIND_BITS-1:0] KIND_STAR     = 7'd59;
  localparam logic [KIND_BITS-1:0] KIND_SLASH    = 7'd60;
  localparam logic [KIND_BITS-1:0] KIND_ASSIGN   = 7'd61;
  localparam logic [KIND_BITS-1:0] KIND_EQ       = 7'd62;
  localparam logic [KIND_BITS-1:0] KIND_NE       = 7'd63;
  localparam logic [KIND_BITS-1:0] KIND_LE       = 7'd64;
  localparam logic [KIND_BITS-1:0] KIND_GE       = 7'd65;
  localparam logic [KIND_BITS-1:0] KIND_LT       = 7'd66;
  localparam logic [KIND_BITS-1:0] KIND_GT       = 7'd67;
  localparam logic [KIND_BITS-1:0] KIND_PLUS_EQ  = 7'd68;
  localparam logic [KIND_BITS-1:0] KIND_MINUS_EQ = 7'd69;
  localparam logic [KIND_BITS-1:0] KIND_STAR_EQ  = 7'd70;
  localparam logic [KIND_BITS-1:0] KIND_SLASH_EQ = 7'd71;
  localparam logic [KIND_BITS-1:0] KIND_CARET    = 7'd72;
  localparam logic [KIND_BITS-1:0] KIND_SEMI     = 7'd73;
  localparam logic [KIND_BITS-1:0] KIND_COMMA    = 7'd74;
  localparam logic [KIND_BITS-1:0] KIND_LPAREN   = 7'd75;
  localparam logic [KIND_BITS-1:0] KIND_RPAREN   = 7'd76;
  localparam logic [KIND_BITS-1:0] KIND_LBRACK   = 7'd77;
  localparam logic [KIND_BITS-1:0] KIND_RBRACK   = 7'd78;
  localparam logic [KIND_BITS-1:0] KIND_LBRACE   = 7'd79;
  localparam logic [KIND_BITS-1:0] KIND_RBRACE   = 7'd80;
  localparam logic [KIND_BITS-1:0] KIND_LCOMMENT = 7'd81;
  localparam logic [KIND_BITS-1:0] KIND_RCOMMENT = 7'd82;
  localparam logic [KIND_BITS-1:0] KIND_COLON    = 7'd83;
  localparam logic [KIND_BITS-1:0] KIND_BAD      = 7'd84;
  localparam logic [KIND_BITS-1:0] KIND_NONE     = 7'd0;

  localparam logic [KW_COUNT-1:0] KW_ALL = {KW_COUNT{1'b1}};

  localparam logic [8*KW_MAX_LEN-1:0] KW_ROM [KW_COUNT] = '{
    "and", "array", "asm", "begin", "break", "case", "const", "constructor",
    "continue", "destructor", "div", "do", "downto", "else", "end", "false",
    "file", "for", "function", "goto", "if", "implementation", "in",
    "inline", "interface", "label", "mod", "nil", "not", "object", "of",
    "on", "operator", "or", "packed", "procedure", "program", "record",
    "repeat", "set", "shl", "shr", "string", "then", "to", "true", "type",
    "unit", "until", "uses", "var", "while", "with", "xor"
  };

  typedef enum logic [1:0] {
    PC_NONE = 2'd0,
    PC_WORD = 2'd1,
    PC_NUM  = 2'd2,
    PC_SYM  = 2'd3
  } pcls_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]     kind;
    logic [LEN_BITS-1:0]      len;
    logic [POSITION_BITS-1:0] pos;
  } res_t;

  // one request's worth of results
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } qent_t;

  function automatic logic [3:0] kw_len(input int k);
    logic [3:0] n;
    n = '0;
    for (int b = 0; b < KW_MAX_LEN; b++) begin
      if (KW_ROM[k][8*b +: 8] != 8'd0) n = n + 4'd1;
    end
    return n;
  endfunction

  // char i of keyword k, zero past its end (literals sit right-justified)
  function automatic logic [7:0] kw_char(input int k, input logic [LEN_BITS-1:0] i);
    logic [3:0] n;
    int         sh;
    n  = kw_len(k);
    sh = 8 * (int'(n) - 1 - int'(i));
    if (i < LEN_BITS'(n)) return KW_ROM[k][sh +: 8];
    return 8'd0;
  endfunction

  function automatic logic [KW_COUNT-1:0] kw_match(input logic [LEN_BITS-1:0] i,
                                                   input logic [7:0] c);
    logic [KW_COUNT-1:0] m;
    m = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      m[k] = (kw_char(k, i) != 8'd0) && (kw_char(k, i) == c);
    end
    return m;
  endfunction

  function automatic logic [KIND_BITS-1:0] sym_kind(input logic [7:0] c);
    logic [KIND_BITS-1:0] r;
    unique case (c)
      "+": r = KIND_PLUS;
      "-": r = KIND_MINUS;
      "*": r = KIND_STAR;
      "/": r = KIND_SLASH;
      "=": r = KIND_EQ;
      "<": r = KIND_LT;
      ">": r = KIND_GT;
      "^": r = KIND_CARET;
      ";": r = KIND_SEMI;
      ",": r = KIND_COMMA;
      "(": r = KIND_LPAREN;
      ")": r = KIND_RPAREN;
      "[": r = KIND_LBRACK;
      "]": r = KIND_RBRACK;
      "{": r = KIND_LBRACE;
      "}": r = KIND_RBRACE;
      ":": r = KIND_COLON;
      default: r = KIND_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [KIND_BITS-1:0] pair_kind(input logic [7:0] a,
                                                     input logic [7:0] b);
    logic [KIND_BITS-1:0] r;
    r = KIND_NONE;
    if (a == ":" && b == "=") r = KIND_ASSIGN;
    if (a == "<" && b == ">") r = KIND_NE;
    if (a == "<" && b == "=") r = KIND_LE;
    if (a == ">" && b == "=") r = KIND_GE;
    if (a == "+" && b == "=") r = KIND_PLUS_EQ;
    if (a == "-" && b == "=") r = KIND_MINUS_EQ;
    if (a == "*" && b == "=") r = KIND_STAR_EQ;
    if (a == "/" && b == "=") r = KIND_SLASH_EQ;
    if (a == "(" && b == "*") r = KIND_LCOMMENT;
    if (a == "*" && b == ")") r = KIND_RCOMMENT;
    return r;
  endfunction

  function automatic logic [KIND_BITS-1:0] close_kind(input pcls_t cls,
                                                      input logic [KW_COUNT-1:0] cand,
                                                      input logic [LEN_BITS-1:0] len,
                                                      input logic dot,
                                                      input logic [7:0] sym);
    logic [KIND_BITS-1:0] r;
    logic                 found;
    r     = KIND_IDENT;
    found = 1'b0;
    unique case (cls)
      PC_WORD: begin
        for (int k = 0; k < KW_COUNT; k++) begin
          if (!found && cand[k] && (LEN_BITS'(kw_len(k)) == len)) begin
            r     = KIND_BITS'(k);
            found = 1'b1;
          end
        end
      end
      PC_NUM: r = dot ? KIND_REAL : KIND_INTEGER;
      PC_SYM: r = (sym_kind(sym) != KIND_NONE) ? sym_kind(sym) : KIND_BAD;
      default: r = KIND_IDENT;
    endcase
    return r;
  endfunction

  function automatic logic [LEN_BITS-1:0] sat_inc(input logic [LEN_BITS-1:0] v);
    if (v >= LEN_BITS'(LENGTH_LIMIT)) return LEN_BITS'(LENGTH_LIMIT);
    return v + 1'b1;
  endfunction

endpackage

// File: hw/rtl/pascal_token_scanner.sv
// pascal token scanner
// input stream: one source byte per request on s_tdata, s_tlast marks the
// last byte of the source; the pending token is flushed after that byte
// output stream: one token per request, kind on m_tuser, length and end
// position on m_tdata, m_tlast on the final token caused by one input byte
// a byte may cause zero, one or two tokens (whitespace makes none of its own)
// front end classifies the byte and updates the pending token and keyword
// candidate mask in the same cycle, so one byte is taken every cycle while the queue is not full
// tokens pass through a 4-entry queue to the back end, which sends one
// token per cycle from an output register while the receiver is ready
// a byte's first token passes through the queue and then the output register
// before it is offered on m_tvalid
// a byte that makes two tokens keeps its queue entry until both are sent, so a
// long run of such bytes drains at one token per cycle and fills the queue
// when the receiver stalls the queue fills and s_tready drops; nothing lost
// reset: synchronous, clears pending token, stream position, the queue and the output valid
module pascal_token_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] character
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] token_length, [31:8] end_position
  output logic [6:0]  m_tuser,   // [6:0] token_kind
  output logic        m_tlast    // last_of_run
);
  import pts_pkg::*;

  qent_t q_wdata, q_rdata;
  logic  q_push, q_full, q_pop, q_nonempty;
  res_t  out_res;

  pts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_char  (s_tdata),
    .in_last  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  pts_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .rdata    (q_rdata)
  );

  pts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res),
    .out_last   (m_tlast)
  );

  // token fields onto the stream buses
  assign m_tuser = out_res.kind;
  assign m_tdata = {out_res.pos, out_res.len};

endmodule

// File: hw/rtl/pts_front.sv
module pts_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_char,
  input  logic                in_last,
  input  logic                q_full,
  output logic                q_push,
  output pts_pkg::qent_t      q_data
);
  import pts_pkg::*;

  pcls_t                     pclass, pclass_next;
  logic [KW_COUNT-1:0]       cand, cand_next;
  logic [LEN_BITS-1:0]       plen, plen_next;
  logic                      dot, dot_next;
  logic [7:0]                psym, psym_next;
  logic [POSITION_BITS-1:0]  pos;

  logic [7:0]                c;
  logic                      is_letter, is_digit, is_sym, is_ws;
  logic [KIND_BITS-1:0]      pk;
  logic                      pair_v, bad_v, close_v, eoi_v, accept;
  pcls_t                     ns_class;
  logic [KW_COUNT-1:0]       ns_cand;
  logic [LEN_BITS-1:0]       ns_len;
  logic                      ns_dot;
  logic [7:0]                ns_sym;
  res_t                      ra, rb, rc;
  logic [POSITION_BITS-1:0]  prev;

  assign accept   = in_valid && in_ready;
  assign in_ready = !q_full;
  assign prev     = pos - 1'b1;

  assign c         = (in_char >= "A" && in_char <= "Z") ? in_char + 8'd32 : in_char;
  assign is_letter = (c >= "a" && c <= "z");
  assign is_digit  = (c >= "0" && c <= "9") || (c == ".");
  assign is_sym    = (sym_kind(c) != KIND_NONE);
  assign is_ws     = (c == " ") || (c == 8'h0a) || (c == 8'h09);
  assign pk        = pair_kind(psym, c);
  assign pair_v    = is_sym && (pclass == PC_SYM) && (pk != KIND_NONE);
  assign bad_v     = !is_letter && !is_digit && !is_sym && !is_ws;

  // old token closes unless the char extends it or merges with it
  assign close_v = (pclass != PC_NONE)
                   && !(is_letter && pclass == PC_WORD)
                   && !(is_digit && (pclass == PC_WORD || pclass == PC_NUM))
                   && !pair_v;

  // pending state after the char, before the end marker flush
  always_comb begin
    ns_class = pclass;
    ns_cand  = cand;
    ns_len   = plen;
    ns_dot   = dot;
    ns_sym   = psym;
    if (is_letter) begin
      if (pclass != PC_WORD) begin
        ns_class = PC_WORD;
        ns_cand  = KW_ALL & kw_match('0, c);
        ns_len   = LEN_BITS'(1);
        ns_dot   = 1'b0;
        ns_sym   = 8'd0;
      end else begin
        ns_cand = cand & kw_match(plen, c);
        ns_len  = sat_inc(plen);
      end
    end else if (is_digit) begin
      if (pclass == PC_WORD) begin
        ns_cand = cand & kw_match(plen, c);
        ns_len  = sat_inc(plen);
      end else if (pclass == PC_NUM) begin
        ns_len = sat_inc(plen);
        ns_dot = dot || (c == ".");
      end else begin
        ns_class = PC_NUM;
        ns_cand  = KW_ALL;
        ns_len   = LEN_BITS'(1);
        ns_dot   = (c == ".");
        ns_sym   = 8'd0;
      end
    end else if (is_sym && !pair_v) begin
      ns_class = PC_SYM;
      ns_cand  = KW_ALL;
      ns_len   = LEN_BITS'(1);
      ns_dot   = 1'b0;
      ns_sym   = c;
    end else begin
      ns_class = PC_NONE;
      ns_cand  = KW_ALL;
      ns_len   = '0;
      ns_dot   = 1'b0;
      ns_sym   = 8'd0;
    end
  end

  always_comb begin
    if (in_last) begin
      pclass_next = PC_NONE;
      cand_next   = KW_ALL;
      plen_next   = '0;
      dot_next    = 1'b0;
      psym_next   = 8'd0;
    end else begin
      pclass_next = ns_class;
      cand_next   = ns_cand;
      plen_next   = ns_len;
      dot_next    = ns_dot;
      psym_next   = ns_sym;
    end
  end

  assign eoi_v = in_last && (ns_class != PC_NONE);

  always_comb begin
    ra.kind = close_kind(pclass, cand, plen, dot, psym);
    ra.len  = plen;
    ra.pos  = prev;
    rb.kind = pair_v ? pk : KIND_BAD;
    rb.len  = pair_v ? LEN_BITS'(2) : LEN_BITS'(1);
    rb.pos  = pos;
    rc.kind = close_kind(ns_class, ns_cand, ns_len, ns_dot, ns_sym);
    rc.len  = ns_len;
    rc.pos  = pos;
  end

  // pack the up to two results of this char, in order
  always_comb begin
    q_data.r0  = close_v ? ra : ((pair_v || bad_v) ? rb : rc);
    q_data.r1  = close_v ? ((pair_v || bad_v) ? rb : rc) : rc;
    q_data.two = (32'(close_v) + 32'(pair_v || bad_v) + 32'(eoi_v)) > 32'd1;
    q_push     = accept && (close_v || pair_v || bad_v || eoi_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pclass <= PC_NONE;
      cand   <= KW_ALL;
      plen   <= '0;
      dot    <= 1'b0;
      psym   <= 8'd0;
      pos    <= '0;
    end else if (accept) begin
      pclass <= pclass_next;
      cand   <= cand_next;
      plen   <= plen_next;
      dot    <= dot_next;
      psym   <= psym_next;
      pos    <= pos + 1'b1;
    end
  end

endmodule

// File: hw/rtl/pts_fifo.sv
module pts_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pts_pkg::qent_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output pts_pkg::qent_t rdata
);
  import pts_pkg::*;

  qent_t                mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr, rptr;
  logic [QPTR_BITS:0]   count;

  assign full     = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
    end
  end

endmodule

// File: hw/rtl/pts_back.sv
module pts_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_nonempty,
  input  pts_pkg::qent_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output pts_pkg::res_t  out_res,
  output logic           out_last
);
  import pts_pkg::*;

  logic idx;
  logic load;

  assign load  = q_nonempty && (!out_valid || out_ready);
  assign q_pop = load && (idx || !q_data.two);

  always_ff @(posedge clk) begin
    if (load) begin
      out_res  <= idx ? q_data.r1 : q_data.r0;
      out_last <= idx || !q_data.two;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (load) idx <= !q_pop;
    end
  end

endmodule

// File: hw/rtl/pts_checker.sv
module pts_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [6:0]  m_tuser
);
  import pts_pkg::*;

  // a stalled token stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("token dropped while stalled");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("token offered after reset");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= KIND_BAD))
    else $error("token kind out of range");

  // unrecognized chars are single, merged symbols are pairs
  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_BAD || m_tuser == KIND_ASSIGN || m_tuser == KIND_NE)
    |-> (m_tdata[7:0] == ((m_tuser == KIND_BAD) ? 8'd1 : 8'd2)))
    else $error("bad token length");

endmodule

bind pascal_token_scanner pts_checker u_pts_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
